@@ hdl/lbc_pkg.sv @@
// Package of shared types and constants for the LRU block cache.
package lbc_pkg;
   localparam int MaxEntries    = 256;
   localparam int WordsPerBlock = 32;
   localparam int SlotBits      = $clog2(MaxEntries);
   localparam int WordBits      = $clog2(WordsPerBlock);
   localparam int CountBits     = $clog2(MaxEntries + 1);
   localparam int KeyBits       = 12;
   localparam int StampBits     = 32;
   localparam int DataBits      = 64;
   localparam int CsrDataBits   = 9;

   localparam logic [1:0] CmdLookup  = 2'd0;
   localparam logic [1:0] CmdUpdate  = 2'd1;
   localparam logic [1:0] CmdInsert  = 2'd2;
   localparam logic [1:0] CmdIgnored = 2'd3;

   localparam logic [1:0] StatOk     = 2'd0;
   localparam logic [1:0] StatMiss   = 2'd1;
   localparam logic [1:0] StatClosed = 2'd2;
   localparam logic [1:0] StatDup    = 2'd3;

   localparam logic CsrOpen  = 1'b0;
   localparam logic CsrCount = 1'b1;

   // Result of one walk over the tag table.
   typedef struct packed {
      logic                hit;
      logic [SlotBits-1:0] hit_slot;
      logic                free;
      logic [SlotBits-1:0] free_slot;
      logic [SlotBits-1:0] lru_slot;
   } search_type;
endpackage

@@ hdl/lbc_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface lbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic [3:0]                   disk_number;
   logic [7:0]                   block_number;
   logic [lbc_pkg::WordBits-1:0] word_index;
   logic [lbc_pkg::DataBits-1:0] data_word;
   modport source (output valid, command, disk_number, block_number, word_index, data_word,
                   input ready);
   modport sink (input valid, command, disk_number, block_number, word_index, data_word,
                 output ready);
endinterface

interface lbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [lbc_pkg::DataBits-1:0] read_word;
   logic                         last;
   modport source (output valid, status, read_word, last, input ready);
   modport sink (input valid, status, read_word, last, output ready);
endinterface

@@ hdl/lru_block_cache.sv @@
// Top level of the fully associative LRU block cache.
// Channel | Ports | Direction | Content
// req     | req.* | in        | command, key, word index, data word
// rsp     | rsp.* | out       | status, read word, last
// csr     | csr_* | in        | write enable, index, data
// A lookup or completing beat walks the configured slot count through one
// comparator; other write beats only fill the beat buffer.
// A write that finds its slot then copies the buffer into the block memory;
// a lookup hit streams its 32 words, one block read each, stalled by a held response.
// Reset clears valid marks, the access clock and the sequencer. Response
// stalls hold the sequencer; no request is taken until the response goes.
module lru_block_cache (
   input  logic                              clock,
   input  logic                              reset,
   lbc_req_if.sink                           req,
   lbc_rsp_if.source                         rsp,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [lbc_pkg::CsrDataBits-1:0]   csr_write_data
);
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_DECIDE = 6'b000100,
      S_COPY   = 6'b001000,
      S_STREAM = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   localparam int BlockAddrBits = lbc_pkg::SlotBits + lbc_pkg::WordBits;

   state_type                        state_ff, state_in;
   logic                             open_ff, open_in;
   logic [lbc_pkg::CountBits-1:0]    count_ff, count_in;
   logic [lbc_pkg::MaxEntries-1:0]   valid_ff, valid_in;
   logic [lbc_pkg::StampBits-1:0]    clock_ff, clock_in;
   logic [1:0]                       cmd_ff, cmd_in;
   logic [lbc_pkg::KeyBits-1:0]      key_ff, key_in;
   logic [lbc_pkg::SlotBits-1:0]     slot_ff, slot_in;
   logic [lbc_pkg::WordBits-1:0]     word_ff, word_in;
   logic [1:0]                       stat_ff, stat_in;
   logic                             rv_ff, rv_in;
   logic                             rlast_ff, rlast_in;
   logic                             start, done, tag_wr, stamp_wr, blk_wr, rd_pend_ff, rd_pend_in;
   lbc_pkg::search_type              res;
   logic [lbc_pkg::DataBits-1:0]     buf_mem [lbc_pkg::WordsPerBlock];
   logic [lbc_pkg::DataBits-1:0]     blk_mem [lbc_pkg::MaxEntries*lbc_pkg::WordsPerBlock];
   logic [lbc_pkg::DataBits-1:0]     buf_rd_ff, blk_rd_ff;
   logic [lbc_pkg::DataBits-1:0]     blk_hold_ff;
   logic [lbc_pkg::WordBits-1:0]     copy_ff, copy_in;
   logic                             copy_go_ff, copy_go_in;
   logic [lbc_pkg::CountBits-1:0]    sat_count;
   logic                             req_fire, rsp_fire;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && !rv_ff;

   // Slot count saturated into the legal range.
   always_comb begin
      sat_count = count_ff;
      if (count_ff < lbc_pkg::CountBits'(2)) sat_count = lbc_pkg::CountBits'(2);
      if (count_ff > lbc_pkg::CountBits'(lbc_pkg::MaxEntries))
         sat_count = lbc_pkg::CountBits'(lbc_pkg::MaxEntries);
   end

   lbc_tag_search u_search (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .key        (key_ff),
      .count      (sat_count),
      .valid_bits (valid_ff),
      .wr_en      (tag_wr),
      .wr_slot    (slot_ff),
      .wr_key     (key_ff),
      .stamp_en   (stamp_wr),
      .stamp_val  (clock_ff),
      .done       (done),
      .result     (res)
   );

   // Beat buffer and block memory.
   always_ff @(posedge clock) begin
      if (req_fire && req.command != lbc_pkg::CmdIgnored && req.command != lbc_pkg::CmdLookup)
         buf_mem[req.word_index] <= req.data_word;
      buf_rd_ff <= buf_mem[copy_ff];
      if (blk_wr) blk_mem[{slot_ff, word_ff}] <= buf_rd_ff;
      blk_rd_ff <= blk_mem[BlockAddrBits'({slot_ff, copy_ff})];
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      open_in    = open_ff;
      count_in   = count_ff;
      valid_in   = valid_ff;
      clock_in   = clock_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      slot_in    = slot_ff;
      word_in    = word_ff;
      stat_in    = stat_ff;
      rv_in      = rv_ff;
      rlast_in   = rlast_ff;
      copy_in    = copy_ff;
      copy_go_in = 1'b0;
      rd_pend_in = 1'b0;
      start      = 1'b0;
      tag_wr     = 1'b0;
      stamp_wr   = 1'b0;
      blk_wr     = 1'b0;
      if (rsp_fire) rv_in = 1'b0;
      if (csr_write_enable) begin
         valid_in = '0;
         unique case (csr_index)
            lbc_pkg::CsrOpen:  open_in  = csr_write_data[0];
            lbc_pkg::CsrCount: count_in = csr_write_data;
            default: ;
         endcase
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req.command != lbc_pkg::CmdIgnored) begin
               cmd_in = req.command;
               key_in = {req.disk_number, req.block_number};
               if (req.command == lbc_pkg::CmdLookup
                   || req.word_index == lbc_pkg::WordBits'(lbc_pkg::WordsPerBlock-1)) begin
                  if (!open_ff) begin
                     stat_in = lbc_pkg::StatClosed; rlast_in = 1'b1; rv_in = 1'b1;
                  end else begin
                     start    = 1'b1;
                     state_in = S_SEARCH;
                  end
               end
            end
         end
         S_SEARCH: if (done) state_in = S_DECIDE;
         S_DECIDE: begin
            copy_in  = '0;
            rlast_in = 1'b1;
            if (cmd_ff == lbc_pkg::CmdLookup) begin
               if (!res.hit) begin
                  stat_in = lbc_pkg::StatMiss; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  slot_in = res.hit_slot; clock_in = clock_ff + 1'b1;
                  state_in = S_RESP;
               end
            end else if (cmd_ff == lbc_pkg::CmdUpdate) begin
               if (!res.hit) begin
                  stat_in = lbc_pkg::StatMiss; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  slot_in = res.hit_slot; clock_in = clock_ff + 1'b1;
                  state_in = S_COPY;
               end
            end else if (res.hit) begin
               stat_in = lbc_pkg::StatDup; rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               slot_in  = res.free ? res.free_slot : res.lru_slot;
               clock_in = clock_ff + 1'b1;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            // The registered buffer word read leads its block write.
            if (copy_go_ff) begin
               blk_wr = 1'b1;
               if (word_ff == lbc_pkg::WordBits'(lbc_pkg::WordsPerBlock-1)) begin
                  tag_wr = 1'b1; stamp_wr = 1'b1;
                  valid_in[slot_ff] = 1'b1;
                  stat_in = lbc_pkg::StatOk; rlast_in = 1'b1; rv_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
            if (state_in == S_COPY) begin
               word_in    = copy_ff;
               copy_in    = copy_ff + 1'b1;
               copy_go_in = 1'b1;
            end
         end
         S_STREAM: begin
            if (rsp_fire || !rv_ff) begin
               if (rd_pend_ff) begin
                  stat_in = lbc_pkg::StatOk; rv_in = 1'b1;
                  rlast_in = (word_ff == lbc_pkg::WordBits'(lbc_pkg::WordsPerBlock-1));
                  if (rlast_in) state_in = S_IDLE;
                  else begin
                     word_in = word_ff + 1'b1; copy_in = word_ff + 1'b1; state_in = S_RESP;
                  end
               end
            end else rd_pend_in = rd_pend_ff;
         end
         S_RESP: begin
            // Stamp the hit slot once, then issue one block read.
            if (copy_ff == '0) stamp_wr = 1'b1;
            word_in = copy_ff; rd_pend_in = 1'b1; state_in = S_STREAM;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         open_ff  <= 1'b0;
         count_ff <= lbc_pkg::CountBits'(lbc_pkg::MaxEntries);
         valid_ff <= '0;
         clock_ff <= '0;
         rv_ff    <= 1'b0;
         copy_go_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         clock_ff <= clock_in;
         rv_ff    <= rv_in;
         copy_go_ff <= copy_go_in;
         rd_pend_ff <= rd_pend_in;
      end
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      slot_ff  <= slot_in;
      word_ff  <= word_in;
      stat_ff  <= stat_in;
      rlast_ff <= rlast_in;
      copy_ff  <= copy_in;
   end

   // Hold the streamed word while the response waits.
   always_ff @(posedge clock) begin
      if (state_ff == S_STREAM && rd_pend_ff && (rsp_fire || !rv_ff)) blk_hold_ff <= blk_rd_ff;
   end

   assign rsp.valid     = rv_ff;
   assign rsp.status    = stat_ff;
   assign rsp.read_word = (stat_ff == lbc_pkg::StatOk && cmd_ff == lbc_pkg::CmdLookup)
                          ? blk_hold_ff : '0;
   assign rsp.last      = rlast_ff;

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("request taken while busy");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != lbc_pkg::StatOk) |-> rsp.last) else $error("status not last");
`endif
endmodule

@@ hdl/lbc_tag_search.sv @@
// Sequential tag walk with one shared key and stamp comparator.
module lbc_tag_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [lbc_pkg::KeyBits-1:0]           key,
   input  logic [lbc_pkg::CountBits-1:0]         count,
   input  logic [lbc_pkg::MaxEntries-1:0]        valid_bits,
   input  logic                                  wr_en,
   input  logic [lbc_pkg::SlotBits-1:0]          wr_slot,
   input  logic [lbc_pkg::KeyBits-1:0]           wr_key,
   input  logic                                  stamp_en,
   input  logic [lbc_pkg::StampBits-1:0]         stamp_val,
   output logic                                  done,
   output lbc_pkg::search_type                   result
);
   logic [lbc_pkg::KeyBits-1:0]   key_mem [lbc_pkg::MaxEntries];
   logic [lbc_pkg::StampBits-1:0] stamp_mem [lbc_pkg::MaxEntries];
   logic [lbc_pkg::KeyBits-1:0]   rd_key_ff;
   logic [lbc_pkg::StampBits-1:0] rd_stamp_ff;
   logic                          busy_ff, busy_in;
   logic                          cmp_ff, cmp_in;
   logic [lbc_pkg::CountBits-1:0] addr_ff, addr_in;
   logic [lbc_pkg::SlotBits-1:0]  cmp_slot_ff, cmp_slot_in;
   logic [lbc_pkg::StampBits-1:0] best_ff, best_in;
   lbc_pkg::search_type           res_ff, res_in;
   logic                          done_ff, done_in;
   logic                          cv;

   // Tag and stamp memories, one registered read port each.
   always_ff @(posedge clock) begin
      if (wr_en) key_mem[wr_slot] <= wr_key;
      if (stamp_en) stamp_mem[wr_slot] <= stamp_val;
      rd_key_ff   <= key_mem[addr_ff[lbc_pkg::SlotBits-1:0]];
      rd_stamp_ff <= stamp_mem[addr_ff[lbc_pkg::SlotBits-1:0]];
   end

   assign cv = valid_bits[cmp_slot_ff];

   // Walk: issue a read each cycle, compare the entry read in the cycle before.
   always_comb begin
      busy_in     = busy_ff;
      addr_in     = addr_ff;
      cmp_in      = 1'b0;
      cmp_slot_in = cmp_slot_ff;
      best_in     = best_ff;
      res_in      = res_ff;
      done_in     = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         addr_in = '0;
         res_in  = '0;
      end else if (busy_ff) begin
         if (addr_ff < count) begin
            cmp_in      = 1'b1;
            cmp_slot_in = addr_ff[lbc_pkg::SlotBits-1:0];
            addr_in     = addr_ff + 1'b1;
         end else if (!cmp_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (cmp_ff) begin
         if (cv && rd_key_ff == key && !res_in.hit) begin
            res_in.hit      = 1'b1;
            res_in.hit_slot = cmp_slot_ff;
         end
         if (!cv && !res_in.free) begin
            res_in.free      = 1'b1;
            res_in.free_slot = cmp_slot_ff;
         end
         if (cmp_slot_ff == '0 || rd_stamp_ff < best_ff) begin
            best_in         = rd_stamp_ff;
            res_in.lru_slot = cmp_slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cmp_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cmp_ff  <= cmp_in;
         done_ff <= done_in;
      end
      addr_ff     <= addr_in;
      cmp_slot_ff <= cmp_slot_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
